// File: rtl/spb_pkg.sv
`timescale 1ns / 1ps

package spb_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_ALPHA = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HONOR_MASK  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_COLOR  = 3'd4;

	localparam logic [7:0]  BRIGHTNESS_RST = 8'd255;
	localparam logic [15:0] MASK_COLOR_RST = 16'hF81F;

	// Packed channel masks
	localparam logic [31:0] PK16 = 32'h07E0_F81F;
	localparam logic [31:0] RB32 = 32'h00FF_00FF;
	localparam logic [31:0] G32  = 32'h0000_FF00;

	localparam logic [7:0] BRIGHT_FULL = 8'd255;
	localparam logic [8:0] SCALE_ONE32 = 9'd256;
	localparam logic [8:0] SCALE_ONE16 = 9'd32;

	typedef enum logic [2:0] {
		K_A16  = 3'd0,
		K_P16  = 3'd1,
		K_A32  = 3'd2,
		K_P32  = 3'd3,
		K_COPY = 3'd4,
		K_ZERO = 3'd5
	} kind_t;

	typedef struct packed {
		logic        pixel_depth;
		logic        pixel_alpha;
		logic [7:0]  brightness;
		logic        honor_mask;
		logic [15:0] mask_color;
	} cfg_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_adv_t;

	typedef struct packed {
		kind_t       kind;
		logic        we;
		logic [31:0] m1;
		logic [31:0] m2;
		logic [31:0] src;
		logic [31:0] dst;
		logic [8:0]  n;
	} scaled_t;

	typedef struct packed {
		kind_t       kind;
		logic        we;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] add1;
		logic [31:0] add2;
	} weighted_t;

	function automatic logic [31:0] spread16(input logic [15:0] p);
		return ({16'b0, p} | {p, 16'b0}) & PK16;
	endfunction

	function automatic logic [15:0] fold16(input logic [31:0] c);
		return c[15:0] | c[31:16];
	endfunction

endpackage

// File: rtl/spb_cfg.sv
`timescale 1ns / 1ps

module spb_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [spb_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [spb_pkg::CFG_DATA_W-1:0]   wr_data,
	output spb_pkg::cfg_t                    cfg
);
	import spb_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_depth <= 1'b0;
			cfg_q.pixel_alpha <= 1'b0;
			cfg_q.brightness  <= BRIGHTNESS_RST;
			cfg_q.honor_mask  <= 1'b0;
			cfg_q.mask_color  <= MASK_COLOR_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_PIXEL_DEPTH: cfg_q.pixel_depth <= wr_data[0];
				REG_PIXEL_ALPHA: cfg_q.pixel_alpha <= wr_data[0];
				REG_BRIGHTNESS:  cfg_q.brightness  <= wr_data[7:0];
				REG_HONOR_MASK:  cfg_q.honor_mask  <= wr_data[0];
				REG_MASK_COLOR:  cfg_q.mask_color  <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/spb_scale.sv
`timescale 1ns / 1ps

// Stage 1 decodes the mode per word, stage 2 scales the source by brightness.
module spb_scale (
	input  logic                clk,
	input  spb_pkg::stage_adv_t adv,
	input  spb_pkg::cfg_t       cfg,
	input  logic [31:0]         source_word,
	input  logic [31:0]         dest_pixel,
	output spb_pkg::scaled_t    scaled
);
	import spb_pkg::*;

	kind_t       kind_c;
	logic        we_c;
	logic [8:0]  n_c;
	logic [8:0]  b_plus7;
	logic        masked;

	kind_t       kind_s1;
	logic        we_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic [8:0]  n_s1;

	logic [31:0] op1;
	scaled_t     scaled_s2;

	always_comb begin
		b_plus7 = {1'b0, cfg.brightness} + 9'd7;
		masked  = cfg.honor_mask && (source_word[15:0] == cfg.mask_color);
		kind_c  = K_ZERO;
		we_c    = 1'b1;
		n_c     = '0;
		if (!cfg.pixel_depth) begin
			// (b+7)/8 is already 0 at b=0 and 32 at b=255
			n_c = {3'b0, b_plus7[8:3]};
			if (cfg.pixel_alpha) begin
				kind_c = K_A16;
			end else if (masked) begin
				kind_c = K_ZERO;
				we_c   = 1'b0;
			end else begin
				kind_c = K_P16;
			end
		end else begin
			if (cfg.pixel_alpha) begin
				kind_c = K_A32;
				n_c    = (cfg.brightness == BRIGHT_FULL) ? SCALE_ONE32 : {1'b0, cfg.brightness};
			end else if (cfg.brightness == BRIGHT_FULL) begin
				kind_c = K_COPY;
			end else if (cfg.brightness == '0) begin
				kind_c = K_ZERO;
			end else begin
				kind_c = K_P32;
				n_c    = SCALE_ONE32 - {1'b0, cfg.brightness};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			kind_s1 <= kind_c;
			we_s1   <= we_c;
			src_s1  <= source_word;
			dst_s1  <= dest_pixel;
			n_s1    <= n_c;
		end
	end

	always_comb begin
		case (kind_s1)
			K_P16:   op1 = spread16(src_s1[15:0]);
			K_A32:   op1 = src_s1 & RB32;
			default: op1 = src_s1 & PK16;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			scaled_s2.kind <= kind_s1;
			scaled_s2.we   <= we_s1;
			scaled_s2.m1   <= op1 * 32'(n_s1);
			scaled_s2.m2   <= (src_s1 & G32) * 32'(n_s1);
			scaled_s2.src  <= src_s1;
			scaled_s2.dst  <= dst_s1;
			scaled_s2.n    <= n_s1;
		end
	end

	assign scaled = scaled_s2;

endmodule

// File: rtl/spb_blend.sv
`timescale 1ns / 1ps

// Stage 3 forms the differences and weights, stage 4 applies the weights.
module spb_blend (
	input  logic                clk,
	input  spb_pkg::stage_adv_t adv,
	input  spb_pkg::scaled_t    scaled,
	output spb_pkg::weighted_t  weighted
);
	import spb_pkg::*;

	logic [31:0] xs16;
	logic [31:0] ys16;
	logic [31:0] xrb;
	logic [31:0] xg;
	logic [31:0] yrb;
	logic [31:0] yg;
	logic [8:0]  a32;

	logic [31:0] diff1_c;
	logic [31:0] diff2_c;
	logic [31:0] add1_c;
	logic [31:0] add2_c;
	logic [8:0]  w_c;

	kind_t       kind_s3;
	logic        we_s3;
	logic [31:0] diff1_s3;
	logic [31:0] diff2_s3;
	logic [31:0] add1_s3;
	logic [31:0] add2_s3;
	logic [8:0]  w_s3;

	weighted_t   weighted_s4;

	always_comb begin
		xs16 = (scaled.m1 >> 5) & PK16;
		ys16 = spread16(scaled.dst[15:0]);
		xrb  = (scaled.m1 >> 8) & RB32;
		xg   = (scaled.m2 >> 8) & G32;
		yrb  = scaled.dst & RB32;
		yg   = scaled.dst & G32;
		a32  = {1'b0, scaled.src[31:24]} + {8'b0, |scaled.src[31:24]};

		diff1_c = '0;
		diff2_c = '0;
		add1_c  = '0;
		add2_c  = '0;
		w_c     = '0;
		case (scaled.kind)
			K_A16: begin
				diff1_c = xs16 - ys16;
				add1_c  = ys16;
				w_c     = {3'b0, scaled.src[10:5]};
			end
			K_P16: begin
				// weight of one whole leaves the scaled source as it is
				diff1_c = xs16;
				w_c     = SCALE_ONE16;
			end
			K_A32: begin
				diff1_c = xrb - yrb;
				diff2_c = xg - yg;
				add1_c  = yrb;
				add2_c  = yg;
				w_c     = a32;
			end
			K_P32: begin
				// the red-blue sum adds the whole source word
				diff1_c = 32'd0 - (scaled.src & RB32);
				diff2_c = 32'd0 - (scaled.src & G32);
				add1_c  = scaled.src;
				add2_c  = scaled.src & G32;
				w_c     = scaled.n;
			end
			K_COPY: begin
				add1_c = scaled.src;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			kind_s3  <= scaled.kind;
			we_s3    <= scaled.we;
			diff1_s3 <= diff1_c;
			diff2_s3 <= diff2_c;
			add1_s3  <= add1_c;
			add2_s3  <= add2_c;
			w_s3     <= w_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			weighted_s4.kind <= kind_s3;
			weighted_s4.we   <= we_s3;
			weighted_s4.p1   <= diff1_s3 * 32'(w_s3);
			weighted_s4.p2   <= diff2_s3 * 32'(w_s3);
			weighted_s4.add1 <= add1_s3;
			weighted_s4.add2 <= add2_s3;
		end
	end

	assign weighted = weighted_s4;

endmodule

// File: rtl/spb_pack.sv
`timescale 1ns / 1ps

// Stage 5: final shift and add, repacking, and the output register.
module spb_pack (
	input  logic                clk,
	input  spb_pkg::stage_adv_t adv,
	input  spb_pkg::weighted_t  weighted,
	output logic [31:0]         out_pixel,
	output logic                write_enable
);
	import spb_pkg::*;

	logic [31:0] sum16;
	logic [31:0] rb32;
	logic [31:0] g32;
	logic [31:0] pix_c;

	logic [31:0] pix_s5;
	logic        we_s5;

	always_comb begin
		sum16 = ((weighted.p1 >> 5) + weighted.add1) & PK16;
		rb32  = (weighted.p1 >> 8) + weighted.add1;
		g32   = (weighted.p2 >> 8) + weighted.add2;
		case (weighted.kind)
			K_A16, K_P16: pix_c = {16'b0, fold16(sum16)};
			K_A32, K_P32: pix_c = (rb32 & RB32) | (g32 & G32);
			K_COPY:       pix_c = weighted.add1;
			default:      pix_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			pix_s5 <= pix_c;
			we_s5  <= weighted.we;
		end
	end

	assign out_pixel    = pix_s5;
	assign write_enable = we_s5;

endmodule

// File: rtl/sprite_pixel_blend_unit.sv
`timescale 1ns / 1ps

// Sprite pixel blender for a blitter. Each input word pairs a sprite source word with the
// destination pixel it lands on; the unit returns the pixel to store and a write flag.
// Pixels are either RGB565 in the low 16 bits or 32-bit RGB, the source may carry per-pixel
// alpha, a brightness register darkens the source, and in 16-bit plain mode a colour key can
// suppress the write. The unit takes one word every clock cycle while in_stall is low and
// returns its result through five register stages (decode, brightness scaling multiply,
// difference forming, alpha weighting multiply, repack into the output register). Each stage
// moves on whenever the stage after it is empty or moving, so bubbles are squeezed out and
// in_stall only rises once every stage holds a word and the output is stalled. Configuration
// writes are always accepted (cfg_ready is high) and should only be made while no word is in
// flight.
module sprite_pixel_blend_unit (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [spb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spb_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [31:0]                     source_word,
	input  logic [31:0]                     dest_pixel,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [31:0]                     out_pixel,
	output logic                            write_enable
);
	import spb_pkg::*;

	cfg_t       cfg;
	stage_adv_t adv;
	scaled_t    scaled;
	weighted_t  weighted;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;

	// The register file never pushes back.
	assign cfg_ready = 1'b1;

	spb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// A stage advances when it is empty or when the stage after it advances as well.
	// The chain starts at the output register, which frees up when its word is taken.
	always_comb begin
		adv.s5 = !valid_s5 || !out_stall;
		adv.s4 = !valid_s4 || adv.s5;
		adv.s3 = !valid_s3 || adv.s4;
		adv.s2 = !valid_s2 || adv.s3;
		adv.s1 = !valid_s1 || adv.s2;
	end

	assign in_stall  = !adv.s1;
	assign out_valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv.s1) begin
				valid_s1 <= in_valid;
			end
			if (adv.s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv.s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv.s4) begin
				valid_s4 <= valid_s3;
			end
			if (adv.s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	spb_scale u_scale (
		.clk         (clk),
		.adv         (adv),
		.cfg         (cfg),
		.source_word (source_word),
		.dest_pixel  (dest_pixel),
		.scaled      (scaled)
	);

	spb_blend u_blend (
		.clk      (clk),
		.adv      (adv),
		.scaled   (scaled),
		.weighted (weighted)
	);

	spb_pack u_pack (
		.clk          (clk),
		.adv          (adv),
		.weighted     (weighted),
		.out_pixel    (out_pixel),
		.write_enable (write_enable)
	);

	// Back-pressure only reaches the input once the whole pipeline is full and stalled.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5 && out_stall))
		else $error("input stalled while the pipeline still has room");

	// A word in stage 4 moving on must appear at the output on the next cycle.
	a_stage4_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && adv.s5) |=> out_valid)
		else $error("word lost between stage 4 and the output register");

	// A suppressed write always carries a zero pixel.
	a_masked_pixel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_enable) |-> (out_pixel == '0))
		else $error("masked word with a non-zero pixel");

endmodule
